// File: hw/rtl/vdma_pkg.sv
// Types and constants for the vehicle drive mode arbiter.
// Used by all vdma modules; no dependencies.
package vdma_pkg;

  localparam int unsigned WR_DATA_WIDTH  = 16;
  localparam int unsigned WR_INDEX_WIDTH = 2;

  // register indexes
  localparam logic [WR_INDEX_WIDTH-1:0] REG_FULL_SPEED      = 2'd0;
  localparam logic [WR_INDEX_WIDTH-1:0] REG_MAX_STEER       = 2'd1;
  localparam logic [WR_INDEX_WIDTH-1:0] REG_DEAD_ZONE       = 2'd2;
  localparam logic [WR_INDEX_WIDTH-1:0] REG_BRAKE_THRESHOLD = 2'd3;

  // register reset values
  localparam logic [14:0] FULL_SPEED_RST      = 15'd998;
  localparam logic [14:0] MAX_STEER_RST       = 15'd11438;
  localparam logic [14:0] DEAD_ZONE_RST       = 15'd3277;
  localparam logic [15:0] BRAKE_THRESHOLD_RST = 16'd3277;

  // event kinds
  localparam logic [1:0] CMD_JOYSTICK = 2'd0;
  localparam logic [1:0] CMD_AUTO     = 2'd1;
  localparam logic [1:0] CMD_HEALTH   = 2'd2;

  // drive modes
  localparam logic [1:0] MODE_HARD   = 2'd0;
  localparam logic [1:0] MODE_FAIL   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;
  localparam logic [1:0] MODE_AUTO   = 2'd3;

  localparam logic [15:0] BRAKE_FULL = 16'd32768;
  localparam logic [15:0] BRAKE_SOFT = 16'd22938;
  localparam logic [15:0] BRAKE_HALF = 16'd16384;

  // floor(v / 9) = (v * DIV9_MUL) >> DIV9_SHIFT, exact for v < 2**21
  localparam logic [18:0] DIV9_MUL   = 19'd466034;
  localparam int unsigned DIV9_SHIFT = 22;

  typedef struct packed {
    logic [14:0] full_speed;
    logic [14:0] max_steer;
    logic [14:0] dead_zone;
    logic [15:0] brake_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         command;
    logic               button_a;
    logic               button_b;
    logic               button_x;
    logic               button_l1;
    logic               button_r1;
    logic signed [15:0] forward_axis;
    logic signed [15:0] steer_axis;
    logic signed [15:0] auto_speed;
    logic [15:0]        auto_brake;
    logic signed [15:0] auto_steer;
    logic               health_good;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               healthy;
    logic signed [15:0] speed;
    logic [15:0]        brake;
    logic               em_release;
    logic signed [15:0] steer;
  } state_t;

  typedef struct packed {
    logic signed [15:0] speed_out;
    logic [15:0]        brake_out;
    logic               em_brake_release;
    logic signed [15:0] steer_out;
    logic [1:0]         mode_out;
  } result_t;

endpackage

// File: hw/rtl/vdma_if.sv
// Valid/ready channel interfaces for the drive mode arbiter.
// No dependencies.
interface vdma_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               button_a;
  logic               button_b;
  logic               button_x;
  logic               button_l1;
  logic               button_r1;
  logic signed [15:0] forward_axis;
  logic signed [15:0] steer_axis;
  logic signed [15:0] auto_speed;
  logic [15:0]        auto_brake;
  logic signed [15:0] auto_steer;
  logic               health_good;

  modport source (
    output valid, command, button_a, button_b, button_x, button_l1, button_r1,
           forward_axis, steer_axis, auto_speed, auto_brake, auto_steer, health_good,
    input  ready
  );
  modport sink (
    input  valid, command, button_a, button_b, button_x, button_l1, button_r1,
           forward_axis, steer_axis, auto_speed, auto_brake, auto_steer, health_good,
    output ready
  );
endinterface

interface vdma_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_out;
  logic [15:0]        brake_out;
  logic               em_brake_release;
  logic signed [15:0] steer_out;
  logic [1:0]         mode_out;

  modport source (
    output valid, speed_out, brake_out, em_brake_release, steer_out, mode_out,
    input  ready
  );
  modport sink (
    input  valid, speed_out, brake_out, em_brake_release, steer_out, mode_out,
    output ready
  );
endinterface

// File: hw/rtl/vdma_cfg.sv
// Configuration register file of the drive mode arbiter.
// Depends on vdma_pkg.
module vdma_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [vdma_pkg::WR_INDEX_WIDTH-1:0] wr_index,
  input  logic [vdma_pkg::WR_DATA_WIDTH-1:0]  wr_data,
  output vdma_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_speed      <= vdma_pkg::FULL_SPEED_RST;
      cfg.max_steer       <= vdma_pkg::MAX_STEER_RST;
      cfg.dead_zone       <= vdma_pkg::DEAD_ZONE_RST;
      cfg.brake_threshold <= vdma_pkg::BRAKE_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        vdma_pkg::REG_FULL_SPEED:      cfg.full_speed      <= wr_data[14:0];
        vdma_pkg::REG_MAX_STEER:       cfg.max_steer       <= wr_data[14:0];
        vdma_pkg::REG_DEAD_ZONE:       cfg.dead_zone       <= wr_data[14:0];
        vdma_pkg::REG_BRAKE_THRESHOLD: cfg.brake_threshold <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/vdma_eval.sv
// Event evaluation: mode arbitration, stick scaling and autonomous pass-through.
// Purely combinational; depends on vdma_pkg.
module vdma_eval (
  input  vdma_pkg::cfg_t     cfg,
  input  vdma_pkg::state_t   state,
  input  vdma_pkg::in_item_t item,
  output vdma_pkg::state_t   state_next,
  output vdma_pkg::result_t  result,
  output logic               emit
);

  logic [1:0]         mode_joy;
  logic signed [31:0] steer_prod;
  logic signed [31:0] steer_rnd;
  logic signed [31:0] steer_shr;
  logic [16:0]        mag;
  logic               below_dz;
  logic [16:0]        fwd_off;
  logic [29:0]        speed_prod;
  logic [30:0]        speed_rnd;
  logic [16:0]        brake_diff;
  logic [17:0]        brake_num;
  logic [36:0]        brake_prod;
  logic [14:0]        brake_quot;
  logic [16:0]        brake_sum;
  logic [15:0]        brake_man;
  logic [15:0]        brake_auto;

  always_comb begin
    mode_joy = state.mode;
    if (item.button_b) begin
      mode_joy = vdma_pkg::MODE_HARD;
    end else if (item.button_r1) begin
      mode_joy = vdma_pkg::MODE_FAIL;
    end else if (item.button_x || item.button_l1) begin
      mode_joy = vdma_pkg::MODE_MANUAL;
    end else if (item.button_a) begin
      if (!state.healthy) begin
        mode_joy = vdma_pkg::MODE_FAIL;
      end else if (state.mode == vdma_pkg::MODE_HARD) begin
        mode_joy = vdma_pkg::MODE_AUTO;
      end
    end
  end

  // steering: round half up of stick * max_steer / 2**15, always in range
  assign steer_prod = item.steer_axis * $signed({1'b0, cfg.max_steer});
  assign steer_rnd  = steer_prod + 32'sd16384;
  assign steer_shr  = steer_rnd >>> 15;

  assign mag      = item.forward_axis[15] ? 17'(-$signed({item.forward_axis[15],
                                                           item.forward_axis}))
                                          : {1'b0, item.forward_axis};
  assign below_dz = mag < {2'b00, cfg.dead_zone};

  // forward speed, used only when forward >= dead_zone
  assign fwd_off    = 17'($signed({item.forward_axis[15], item.forward_axis})
                          - $signed({2'b00, cfg.dead_zone}));
  assign speed_prod = fwd_off[14:0] * cfg.full_speed;
  assign speed_rnd  = {1'b0, speed_prod} + 31'd16384;

  // reverse stick brake: round((mag - dz) * 5 / 9) + half, saturated
  assign brake_diff = mag - {2'b00, cfg.dead_zone};
  assign brake_num  = 18'({brake_diff, 2'b00}) + 18'(brake_diff) + 18'd4;
  assign brake_prod = brake_num * vdma_pkg::DIV9_MUL;
  assign brake_quot = brake_prod[vdma_pkg::DIV9_SHIFT +: 15];
  assign brake_sum  = {2'b00, brake_quot} + {1'b0, vdma_pkg::BRAKE_HALF};
  assign brake_man  = (brake_sum > {1'b0, vdma_pkg::BRAKE_FULL}) ? vdma_pkg::BRAKE_FULL
                                                                : brake_sum[15:0];

  assign brake_auto = (item.auto_brake > vdma_pkg::BRAKE_FULL) ? vdma_pkg::BRAKE_FULL
                                                              : item.auto_brake;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    case (item.command)
      vdma_pkg::CMD_JOYSTICK: begin
        state_next.mode  = mode_joy;
        state_next.steer = steer_shr[15:0];
        case (mode_joy)
          vdma_pkg::MODE_MANUAL: begin
            state_next.em_release = 1'b1;
            if (below_dz) begin
              state_next.speed = '0;
              state_next.brake = '0;
            end else if (!item.forward_axis[15] && item.forward_axis != 16'sd0) begin
              state_next.speed = speed_rnd[30:15];
              state_next.brake = '0;
            end else if (item.forward_axis[15]) begin
              state_next.speed = '0;
              state_next.brake = brake_man;
            end
            emit = 1'b1;
          end
          vdma_pkg::MODE_HARD: begin
            state_next.speed      = '0;
            state_next.em_release = 1'b0;
            state_next.brake      = vdma_pkg::BRAKE_FULL;
            emit                  = 1'b1;
          end
          vdma_pkg::MODE_FAIL: begin
            state_next.speed      = '0;
            state_next.em_release = 1'b0;
            state_next.brake      = vdma_pkg::BRAKE_SOFT;
            emit                  = 1'b1;
          end
          default: ;
        endcase
      end
      vdma_pkg::CMD_AUTO: begin
        if (state.mode == vdma_pkg::MODE_AUTO) begin
          emit = 1'b1;
          if (!state.healthy) begin
            state_next.mode       = vdma_pkg::MODE_FAIL;
            state_next.speed      = '0;
            state_next.em_release = 1'b0;
            state_next.brake      = vdma_pkg::BRAKE_SOFT;
          end else begin
            if (item.auto_brake > cfg.brake_threshold) begin
              state_next.brake = brake_auto;
              state_next.speed = '0;
            end else begin
              state_next.brake = '0;
              state_next.speed = item.auto_speed;
            end
            state_next.em_release = 1'b1;
            state_next.steer      = item.auto_steer;
          end
        end
      end
      vdma_pkg::CMD_HEALTH: begin
        state_next.healthy = item.health_good;
      end
      default: ;
    endcase
  end

  assign result.speed_out        = state_next.speed;
  assign result.brake_out        = state_next.brake;
  assign result.em_brake_release = state_next.em_release;
  assign result.steer_out        = state_next.steer;
  assign result.mode_out         = state_next.mode;

endmodule

// File: hw/rtl/vehicle_drive_mode_arbiter_top.sv
// Top level of the vehicle drive mode arbiter: input register, state, result register.
// Depends on vdma_pkg, vdma_if, vdma_cfg and vdma_eval.
//
//   channel   role    handshake      payload
//   in_ch     sink    valid/ready    event: command, buttons, axes, auto fields, health
//   out_ch    source  valid/ready    speed, brake, em release, steer, mode
//   wr_*      sink    wr_en only     register index and data
//
// One event per cycle sustained while the result is not stalled.
// An event passes the input register, then the result register; only events that emit give a result.
// Synchronous reset clears the pipeline valids, mode, health flag and the rest of the state.
// A stalled result holds the evaluation stage; the input register still takes
// a new event while its slot is empty or moving on.
module vehicle_drive_mode_arbiter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [vdma_pkg::WR_INDEX_WIDTH-1:0] wr_index,
  input  logic [vdma_pkg::WR_DATA_WIDTH-1:0]  wr_data,
  vdma_in_if.sink                             in_ch,
  vdma_out_if.source                          out_ch
);

  vdma_pkg::cfg_t     cfg;
  vdma_pkg::in_item_t item;
  vdma_pkg::state_t   state;
  vdma_pkg::state_t   state_next;
  vdma_pkg::result_t  result;
  vdma_pkg::result_t  res_q;
  logic               emit;
  logic               item_valid;
  logic               res_valid;
  logic               advance;

  vdma_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  vdma_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result),
    .emit       (emit)
  );

  assign advance     = item_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.command      <= in_ch.command;
      item.button_a     <= in_ch.button_a;
      item.button_b     <= in_ch.button_b;
      item.button_x     <= in_ch.button_x;
      item.button_l1    <= in_ch.button_l1;
      item.button_r1    <= in_ch.button_r1;
      item.forward_axis <= in_ch.forward_axis;
      item.steer_axis   <= in_ch.steer_axis;
      item.auto_speed   <= in_ch.auto_speed;
      item.auto_brake   <= in_ch.auto_brake;
      item.auto_steer   <= in_ch.auto_steer;
      item.health_good  <= in_ch.health_good;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= emit;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res_q <= result;
    end
  end

  assign out_ch.valid            = res_valid;
  assign out_ch.speed_out        = res_q.speed_out;
  assign out_ch.brake_out        = res_q.brake_out;
  assign out_ch.em_brake_release = res_q.em_brake_release;
  assign out_ch.steer_out        = res_q.steer_out;
  assign out_ch.mode_out         = res_q.mode_out;

endmodule
